// File: sv/twac_pkg.sv
// ----------------------------------------------------------------------------
// twac_pkg
// Shared widths, codes and limits for the travel window average and
// calibration block.
// ----------------------------------------------------------------------------
package twac_pkg;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 20;
	localparam int OFFSET_W = 12;
	localparam int SPAN_W   = 10;
	localparam int VALUE_W  = 23;
	localparam int MODE_W   = 2;
	localparam int KIND_W   = 2;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam int SAG_SCALE = 1000;
	localparam int SCALE_W   = 10;
	localparam int NUM_W     = SUM_W + SCALE_W;

	localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
	localparam logic [NUM_W-1:0]    VALUE_MAX  = NUM_W'(4190208);

	localparam logic [SPAN_W-1:0] FRONT_SPAN_RST = SPAN_W'(300);
	localparam logic [SPAN_W-1:0] REAR_SPAN_RST  = SPAN_W'(125);

	localparam logic [MODE_W-1:0] MODE_SAG       = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CALIBRATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NORMALIZE = 2'd2;

	localparam logic [KIND_W-1:0] KIND_SAG    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OFFSET = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TRAVEL = 2'd2;

	localparam logic REG_FRONT_SPAN = 1'b0;
	localparam logic REG_REAR_SPAN  = 1'b1;

endpackage

// File: sv/travel_window_average_calibrate_top.sv
// ----------------------------------------------------------------------------
// travel_window_average_calibrate_top
// Two-channel travel sample accumulator with offset calibration, sag
// measurement and per-sample travel normalization.
// ----------------------------------------------------------------------------
// A sag or calibrate beat without the window end flag leaves the block idle,
// as does an ignored mode code. A normalize beat goes to the emit state and
// waits there while the result register is held by result_stall. A window end
// beat runs both channels through one shared restoring divider that resolves
// one quotient bit per cycle over 30 bits, for a sag or calibrate window end
// alike, with output wait between and after the channels; a sag channel that
// comes out zero skips the divider. item_stall is high throughout any beat
// that leaves idle.
// Span registers sit at byte address 0 (front) and 4 (rear).
module travel_window_average_calibrate_top #(
	parameter int WINDOW_SAMPLES = 256,
	parameter int ADC_FULL_SCALE = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic [twac_pkg::SAMPLE_W-1:0]          sample,
	input  logic                                   channel,
	input  logic [twac_pkg::MODE_W-1:0]            mode,
	input  logic                                   window_end,

	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic                                   result_channel,
	output logic [twac_pkg::KIND_W-1:0]            result_kind,
	output logic signed [twac_pkg::VALUE_W-1:0]    value,
	output logic                                   last,

	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [twac_pkg::ADDR_W-1:0]            paddr,
	input  logic [twac_pkg::DATA_W-1:0]            pwdata,
	output logic [twac_pkg::DATA_W-1:0]            prdata,
	output logic                                   pready
);

	localparam int N_W    = $clog2(WINDOW_SAMPLES + 1);
	localparam int FS_W   = $clog2(ADC_FULL_SCALE + 1);
	localparam int DEN_W  = N_W + FS_W;
	localparam int REM_W  = DEN_W + 1;
	localparam int BASE_W = twac_pkg::OFFSET_W + N_W;
	localparam int CMP_W  = (BASE_W > twac_pkg::SUM_W) ? BASE_W : twac_pkg::SUM_W;
	localparam int OFC_W  = (FS_W > twac_pkg::OFFSET_W) ? FS_W : twac_pkg::OFFSET_W;
	localparam int CNT_W  = $clog2(twac_pkg::NUM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCALE,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	state_t                                 state_q;
	logic                                   ch_q;
	logic [twac_pkg::KIND_W-1:0]            kind_q;
	logic signed [twac_pkg::VALUE_W-1:0]    res_q;
	logic [BASE_W-1:0]                      base_q;
	logic [DEN_W-1:0]                       den_q;
	logic [twac_pkg::NUM_W-1:0]             num_q;
	logic [REM_W-1:0]                       rem_q;
	logic [CNT_W-1:0]                       cnt_q;
	logic                                   zero_q;

	logic [twac_pkg::SUM_W-1:0]             sum_q [2];
	logic [twac_pkg::OFFSET_W-1:0]          off_q [2];
	logic [twac_pkg::SPAN_W-1:0]            front_span_q;
	logic [twac_pkg::SPAN_W-1:0]            rear_span_q;

	logic                                   result_valid_q;
	logic                                   result_channel_q;
	logic [twac_pkg::KIND_W-1:0]            result_kind_q;
	logic signed [twac_pkg::VALUE_W-1:0]    value_q;
	logic                                   last_q;

	logic                                   item_acc;
	logic                                   out_free;
	logic                                   cfg_wr;
	logic                                   rd_ch;
	logic [twac_pkg::SUM_W-1:0]             sum_rd;
	logic [twac_pkg::OFFSET_W-1:0]          off_rd;
	logic [twac_pkg::SUM_W:0]               sum_add;
	logic [twac_pkg::SUM_W-1:0]             sum_next;
	logic [twac_pkg::SPAN_W-1:0]            span_sel;
	logic signed [twac_pkg::OFFSET_W:0]     norm_diff;
	logic signed [twac_pkg::VALUE_W:0]      norm_prod;
	logic                                   off_ge_fs;
	logic [FS_W-1:0]                        fs_diff;
	logic                                   sum_le_base;
	logic [twac_pkg::SUM_W-1:0]             sag_diff;
	logic [REM_W-1:0]                       rem_shift;
	logic                                   rem_ge;
	logic [twac_pkg::OFFSET_W-1:0]          avg_sat;
	logic [twac_pkg::NUM_W-1:0]             sag_sat;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign pready     = 1'b1;

	assign rd_ch  = (state_q == ST_IDLE) ? channel : ch_q;
	assign sum_rd = sum_q[rd_ch];
	assign off_rd = off_q[rd_ch];

	assign sum_add  = {1'b0, sum_rd} + (twac_pkg::SUM_W + 1)'(sample);
	assign sum_next = sum_add[twac_pkg::SUM_W] ? twac_pkg::SUM_MAX
	                                           : sum_add[twac_pkg::SUM_W-1:0];

	assign span_sel  = channel ? rear_span_q : front_span_q;
	assign norm_diff = $signed({1'b0, sample}) - $signed({1'b0, off_rd});
	assign norm_prod = (twac_pkg::VALUE_W + 1)'(norm_diff)
	                 * (twac_pkg::VALUE_W + 1)'($signed({1'b0, span_sel}));

	assign off_ge_fs = OFC_W'(off_rd) >= OFC_W'(ADC_FULL_SCALE);
	assign fs_diff   = FS_W'(ADC_FULL_SCALE) - FS_W'(off_rd);

	assign sum_le_base = CMP_W'(sum_rd) <= CMP_W'(base_q);
	assign sag_diff    = twac_pkg::SUM_W'(CMP_W'(sum_rd) - CMP_W'(base_q));

	assign rem_shift = {rem_q[REM_W-2:0], num_q[twac_pkg::NUM_W-1]};
	assign rem_ge    = rem_shift >= REM_W'(den_q);

	assign avg_sat = (num_q > twac_pkg::NUM_W'(twac_pkg::OFFSET_MAX))
	               ? twac_pkg::OFFSET_MAX : num_q[twac_pkg::OFFSET_W-1:0];
	assign sag_sat = (num_q > twac_pkg::VALUE_MAX) ? twac_pkg::VALUE_MAX : num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_span_q <= twac_pkg::FRONT_SPAN_RST;
			rear_span_q  <= twac_pkg::REAR_SPAN_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				twac_pkg::REG_FRONT_SPAN: front_span_q <= pwdata[twac_pkg::SPAN_W-1:0];
				twac_pkg::REG_REAR_SPAN:  rear_span_q  <= pwdata[twac_pkg::SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			twac_pkg::REG_FRONT_SPAN:
				prdata = twac_pkg::DATA_W'(front_span_q);
			twac_pkg::REG_REAR_SPAN:
				prdata = twac_pkg::DATA_W'(rear_span_q);
			default:
				prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ch_q           <= 1'b0;
			kind_q         <= twac_pkg::KIND_SAG;
			zero_q         <= 1'b0;
			cnt_q          <= '0;
			sum_q[0]       <= '0;
			sum_q[1]       <= '0;
			off_q[0]       <= '0;
			off_q[1]       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						case (mode)
							twac_pkg::MODE_NORMALIZE: begin
								ch_q    <= channel;
								kind_q  <= twac_pkg::KIND_TRAVEL;
								res_q   <= norm_prod[twac_pkg::VALUE_W-1:0];
								state_q <= ST_EMIT;
							end
							twac_pkg::MODE_SAG,
							twac_pkg::MODE_CALIBRATE: begin
								sum_q[channel] <= sum_next;
								if (window_end) begin
									ch_q    <= 1'b0;
									kind_q  <= (mode == twac_pkg::MODE_CALIBRATE)
									         ? twac_pkg::KIND_OFFSET : twac_pkg::KIND_SAG;
									state_q <= ST_PREP;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					rem_q <= '0;
					cnt_q <= CNT_W'(twac_pkg::NUM_W - 1);
					if (kind_q == twac_pkg::KIND_OFFSET) begin
						num_q   <= twac_pkg::NUM_W'(sum_rd);
						den_q   <= DEN_W'(WINDOW_SAMPLES);
						state_q <= ST_DIV;
					end else begin
						zero_q  <= off_ge_fs;
						base_q  <= BASE_W'(WINDOW_SAMPLES) * BASE_W'(off_rd);
						den_q   <= DEN_W'(WINDOW_SAMPLES) * DEN_W'(fs_diff);
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (zero_q || sum_le_base) begin
						res_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						num_q   <= twac_pkg::NUM_W'(twac_pkg::SAG_SCALE)
						         * twac_pkg::NUM_W'(sag_diff);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_ge ? (rem_shift - REM_W'(den_q)) : rem_shift;
					num_q <= {num_q[twac_pkg::NUM_W-2:0], rem_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (kind_q == twac_pkg::KIND_OFFSET) begin
						off_q[ch_q] <= avg_sat;
						res_q       <= twac_pkg::VALUE_W'(avg_sat);
					end else begin
						res_q <= sag_sat[twac_pkg::VALUE_W-1:0];
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						result_valid_q   <= 1'b1;
						result_channel_q <= ch_q;
						result_kind_q    <= kind_q;
						value_q          <= res_q;
						last_q           <= (kind_q == twac_pkg::KIND_TRAVEL) || ch_q;
						if (kind_q == twac_pkg::KIND_TRAVEL) begin
							state_q <= ST_IDLE;
						end else if (ch_q) begin
							sum_q[0] <= '0;
							sum_q[1] <= '0;
							state_q  <= ST_IDLE;
						end else begin
							ch_q    <= 1'b1;
							state_q <= ST_PREP;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid   = result_valid_q;
	assign result_channel = result_channel_q;
	assign result_kind    = result_kind_q;
	assign value          = value_q;
	assign last           = last_q;

endmodule
